>>> hdl/sorted_record_table_core_macros.svh
// Assertion macros shared by the checker of the sorted record table.
`ifndef SORTED_RECORD_TABLE_CORE_MACROS_SVH
`define SORTED_RECORD_TABLE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define SRT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted record table: same-cycle check failed");

// Next-cycle implication, sampled on clk and quiet during reset.
`define SRT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted record table: next-cycle check failed");

`endif

>>> hdl/srt_pkg.sv
// Types and constants shared by the sorted record table modules.
`default_nettype none
package srt_pkg;
    localparam int TABLE_DEPTH = 64;
    localparam int KEY_CHARS = 8;
    localparam int KEY_W = 8 * KEY_CHARS;
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [63:0] KEY_MASK = {64{1'b1}} >> (64 - KEY_W);

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;
    localparam logic [1:0] CMD_READ   = 2'd3;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_RANGE     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_DELETE,
        OP_LOOKUP,
        OP_READ
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_SCAN,
        S_INS_PUT,
        S_DEL_SCAN,
        S_LK_SCAN,
        S_RD_WAIT,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [63:0] name;
        logic [63:0] surname;
        logic [63:0] phone;
    } rec_t;

    typedef struct packed {
        op_t        op;
        rec_t       rec;
        logic [5:0] idx;
    } item_t;
endpackage
`default_nettype wire

>>> hdl/srt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module srt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

>>> hdl/srt_front.sv
// Request intake: masks keys, decodes the command and queues requests for the sequencer.
`default_nettype none
module srt_front
    import srt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  command,
    input  wire logic [63:0] name_key,
    input  wire logic [63:0] surname_key,
    input  wire logic [63:0] phone_value,
    input  wire logic [5:0]  entry_index,
    output logic             q_valid,
    output item_t            q_item,
    input  wire logic        q_take
);
    item_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    item_t      new_item;
    logic       do_push, do_pop;

    always_comb
    begin
        case (command)
            CMD_INSERT: new_item.op = OP_INSERT;
            CMD_DELETE: new_item.op = OP_DELETE;
            CMD_LOOKUP: new_item.op = OP_LOOKUP;
            default:    new_item.op = OP_READ;
        endcase
        new_item.rec.name    = name_key & KEY_MASK;
        new_item.rec.surname = surname_key & KEY_MASK;
        new_item.rec.phone   = phone_value & KEY_MASK;
        new_item.idx         = entry_index;
    end

    assign full    = (fill_reg == 2'd2);
    assign q_valid = (fill_reg != 2'd0);
    assign q_item  = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = q_take && q_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= new_item;
        end
    end
endmodule
`default_nettype wire

>>> hdl/srt_back.sv
// Sequencer: walks the RAM one entry per cycle unless a lookup stalls; drives the result reg.
`default_nettype none
module srt_back
    import srt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    input  item_t            q_item,
    output logic             q_take,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       status,
    output logic [63:0]      out_name,
    output logic [63:0]      out_surname,
    output logic [63:0]      out_phone,
    output logic [6:0]       entry_total,
    output logic             last_result
);
    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [AW-1:0]   ptr_reg, ptr_next;
    logic [CW-1:0]   wptr_reg, wptr_next;
    logic            hit_reg, hit_next;
    logic            pend_reg, pend_next;
    item_t           cur_reg, cur_next;
    status_t         res_status_reg, res_status_next;
    rec_t            res_rec_reg, res_rec_next;
    logic            out_valid_reg, out_valid_next;
    status_t         out_status_reg, out_status_next;
    rec_t            out_rec_reg, out_rec_next;
    logic [CW-1:0]   out_total_reg, out_total_next;
    logic            out_last_reg, out_last_next;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    rec_t            ram_wdata, rdata;

    logic            out_free, rec_match, scan_last, ins_move, lk_step;

    srt_ram #(.WIDTH($bits(rec_t)), .DEPTH(TABLE_DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    assign out_free  = !out_valid_reg || pop;
    assign rec_match = (rdata.name == cur_reg.rec.name)
                       && (rdata.surname == cur_reg.rec.surname);
    assign scan_last = ({1'b0, ptr_reg} == (cnt_reg - CW'(1)));
    assign ins_move  = (rdata.name > cur_reg.rec.name);
    // A second match cannot retire the held one while the result register is busy.
    assign lk_step   = !(rec_match && pend_reg && !out_free);
    assign q_take    = (state_reg == S_IDLE) && q_valid;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_item.op)
                        OP_INSERT:
                        begin
                            if (cnt_reg == CW'(TABLE_DEPTH))
                                state_next = S_EMIT;
                            else if (cnt_reg == '0)
                                state_next = S_INS_PUT;
                            else
                                state_next = S_INS_SCAN;
                        end
                        OP_DELETE: state_next = (cnt_reg == '0) ? S_EMIT : S_DEL_SCAN;
                        OP_LOOKUP: state_next = (cnt_reg == '0) ? S_EMIT : S_LK_SCAN;
                        default:
                            state_next = (7'(q_item.idx) >= 7'(cnt_reg)) ? S_EMIT : S_RD_WAIT;
                    endcase
                end
            end
            S_INS_SCAN:
            begin
                if (!ins_move || ptr_reg == AW'(1))
                    state_next = S_INS_PUT;
            end
            S_INS_PUT: state_next = S_EMIT;
            S_DEL_SCAN:
            begin
                if (scan_last)
                    state_next = S_EMIT;
            end
            S_LK_SCAN:
            begin
                if (lk_step && scan_last)
                    state_next = S_EMIT;
            end
            S_RD_WAIT: state_next = S_EMIT;
            S_EMIT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cnt_next        = cnt_reg;
        ptr_next        = ptr_reg;
        wptr_next       = wptr_reg;
        hit_next        = hit_reg;
        pend_next       = pend_reg;
        cur_next        = cur_reg;
        res_status_next = res_status_reg;
        res_rec_next    = res_rec_reg;
        out_valid_next  = out_valid_reg && !pop;
        out_status_next = out_status_reg;
        out_rec_next    = out_rec_reg;
        out_total_next  = out_total_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = ptr_reg;
        ram_wdata       = rdata;
        ram_raddr       = ptr_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    cur_next     = q_item;
                    hit_next     = 1'b0;
                    pend_next    = 1'b0;
                    wptr_next    = '0;
                    ptr_next     = '0;
                    ram_raddr    = '0;
                    res_rec_next = '0;
                    case (q_item.op)
                        OP_INSERT:
                        begin
                            res_status_next = STAT_FULL;
                            ptr_next        = AW'(cnt_reg);
                            ram_raddr       = AW'(cnt_reg - CW'(1));
                        end
                        OP_DELETE: res_status_next = STAT_NOT_FOUND;
                        OP_LOOKUP: res_status_next = STAT_NOT_FOUND;
                        default:
                        begin
                            res_status_next = STAT_RANGE;
                            ram_raddr       = AW'(q_item.idx);
                        end
                    endcase
                end
            end
            S_INS_SCAN:
            begin
                // Shift the larger entry up and fetch the one below it.
                ram_raddr = ptr_reg - AW'(2);
                if (ins_move)
                begin
                    ram_we   = 1'b1;
                    ptr_next = ptr_reg - AW'(1);
                end
            end
            S_INS_PUT:
            begin
                ram_we          = 1'b1;
                ram_wdata       = cur_reg.rec;
                cnt_next        = cnt_reg + CW'(1);
                res_status_next = STAT_OK;
                res_rec_next    = cur_reg.rec;
            end
            S_DEL_SCAN:
            begin
                ram_raddr = ptr_reg + AW'(1);
                ptr_next  = ptr_reg + AW'(1);
                if (rec_match)
                begin
                    hit_next = 1'b1;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(wptr_reg);
                    wptr_next = wptr_reg + CW'(1);
                end
                if (scan_last)
                begin
                    cnt_next        = wptr_next;
                    res_status_next = hit_next ? STAT_OK : STAT_NOT_FOUND;
                end
            end
            S_LK_SCAN:
            begin
                if (lk_step)
                begin
                    ram_raddr = ptr_reg + AW'(1);
                    ptr_next  = ptr_reg + AW'(1);
                    if (rec_match)
                    begin
                        if (pend_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = STAT_OK;
                            out_rec_next    = res_rec_reg;
                            out_total_next  = cnt_reg;
                            out_last_next   = 1'b0;
                        end
                        pend_next    = 1'b1;
                        res_rec_next = rdata;
                    end
                    if (scan_last)
                    begin
                        res_status_next = pend_next ? STAT_OK : STAT_NOT_FOUND;
                    end
                end
            end
            S_RD_WAIT:
            begin
                res_status_next = STAT_OK;
                res_rec_next    = rdata;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_rec_next    = res_rec_reg;
                    out_total_next  = cnt_reg;
                    out_last_next   = 1'b1;
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            ptr_reg       <= '0;
            wptr_reg      <= '0;
            hit_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ptr_reg       <= ptr_next;
            wptr_reg      <= wptr_next;
            hit_reg       <= hit_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        res_status_reg <= res_status_next;
        res_rec_reg    <= res_rec_next;
        out_status_reg <= out_status_next;
        out_rec_reg    <= out_rec_next;
        out_total_reg  <= out_total_next;
        out_last_reg   <= out_last_next;
    end

    assign empty       = !out_valid_reg;
    assign status      = out_status_reg;
    assign out_name    = out_rec_reg.name;
    assign out_surname = out_rec_reg.surname;
    assign out_phone   = out_rec_reg.phone;
    assign entry_total = 7'(out_total_reg);
    assign last_result = out_last_reg;
endmodule
`default_nettype wire

>>> hdl/sorted_record_table_core.sv
// Top level of the sorted record table: request intake, request queue and table sequencer.
//
//   channel   | handshake           | fields
//   request   | push / full         | command, name_key, surname_key, phone_value, entry_index
//   result    | empty / pop         | status, out_name, out_surname, out_phone, entry_total,
//             |                     | last_result
//
// The sequencer answers a full-table insert, an out-of-range read and a delete or lookup
// on an empty table without a scan. A request passes through the intake queue first, and
// the record RAM, with one write and one read port, moves one entry per cycle unless a
// lookup holds its scan. Up to two requests wait in the queue. A lookup holds its scan
// while a further match needs the result register and a result waits unpopped, and every
// answer waits while a result waits unpopped. Reset empties the table at once.
`default_nettype none
module sorted_record_table_core
    import srt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  command,
    input  wire logic [63:0] name_key,
    input  wire logic [63:0] surname_key,
    input  wire logic [63:0] phone_value,
    input  wire logic [5:0]  entry_index,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       status,
    output logic [63:0]      out_name,
    output logic [63:0]      out_surname,
    output logic [63:0]      out_phone,
    output logic [6:0]       entry_total,
    output logic             last_result
);
    logic  q_valid, q_take;
    item_t q_item;

    srt_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .command     (command),
        .name_key    (name_key),
        .surname_key (surname_key),
        .phone_value (phone_value),
        .entry_index (entry_index),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_take      (q_take)
    );

    srt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_take      (q_take),
        .empty       (empty),
        .pop         (pop),
        .status      (status),
        .out_name    (out_name),
        .out_surname (out_surname),
        .out_phone   (out_phone),
        .entry_total (entry_total),
        .last_result (last_result)
    );
endmodule
`default_nettype wire

>>> hdl/srt_checker.sv
// Port-level checker for the sorted record table, bound to the top level.
`default_nettype none
`include "sorted_record_table_core_macros.svh"
module srt_checker
    import srt_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [1:0]  status,
    input wire logic [63:0] out_name,
    input wire logic [63:0] out_surname,
    input wire logic [63:0] out_phone,
    input wire logic [6:0]  entry_total,
    input wire logic        last_result
);
    // The table never reports more records than it can hold.
    `SRT_ASSERT_NOW(a_total_bound, !empty, entry_total <= 7'(TABLE_DEPTH))
    // A full report only comes from a full table.
    `SRT_ASSERT_NOW(a_full_total, !empty && status == STAT_FULL, entry_total == 7'(TABLE_DEPTH))
    // Any result that is not a success closes its request and carries no record.
    `SRT_ASSERT_NOW(a_fail_last, !empty && status != STAT_OK,
        last_result && (out_name | out_surname | out_phone) == '0)
    // A waiting result stays until it is popped.
    `SRT_ASSERT_NEXT(a_hold, !empty && !pop, !empty)
endmodule

bind sorted_record_table_core srt_checker u_srt_checker (.*);
`default_nettype wire
